// ----- rtl/olpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpht_pkg
// Types, constants and the first key mixing step of the hash table.
// ----------------------------------------------------------------------------
package olpht_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int ENTRY_DEPTH_DEF = 64;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_KEY,
        S_PROBE_EV,
        S_SHIFT_RD,
        S_SHIFT_CHK,
        S_SHIFT_LOAD,
        S_SHIFT_HASH,
        S_DONE
    } olpht_state_t;

    // hash unit: three 32x32 partial products per 64-bit multiply
    typedef enum logic [2:0] {
        HS_IDLE,
        HS_C1_LL,
        HS_C1_HL,
        HS_C1_LH,
        HS_C2_LL,
        HS_C2_HL,
        HS_C2_LH
    } olpht_hstep_t;

    typedef struct packed {
        logic       clear_start;
        logic       clear_step;
        logic       hash_start;
        logic       hash_from_entry;
        logic       load_item;
        logic       probe_start;
        logic       probe_rd;
        logic       probe_adv;
        logic       do_update;
        logic       do_insert;
        logic       do_delete;
        logic       shift_start;
        logic       shift_rd;
        logic       shift_move;
        logic       shift_adv;
        logic       shift_end;
        logic       set_result;
        logic [1:0] result_status;
        logic       result_index;
        logic       result_value;
        logic       out_valid_set;
    } olpht_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       clear_last;
        logic       live_zero;
        logic       hash_busy;
        logic       slot_empty;
        logic       key_match;
        logic       walk_last;
        logic       full;
        logic       move_ok;
        logic       shift_stop;
        logic       out_taken;
    } olpht_sts_t;

    function automatic logic [63:0] mix_pre(input logic [63:0] v);
        mix_pre = v ^ (v >> 30);
    endfunction

endpackage

// ----- rtl/olpht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpht_if
// Valid/ready channel carrying one payload of width W.
// ----------------------------------------------------------------------------
interface olpht_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/olpht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpht_ctrl
// Sequencer for clear, hash, probe and backward-shift walks.
// ----------------------------------------------------------------------------
module olpht_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  olpht_pkg::olpht_sts_t sts,
    output olpht_pkg::olpht_cmd_t cmd
);
    import olpht_pkg::*;

    olpht_state_t state_reg;
    olpht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DECODE:
            begin
                if (sts.op == OP_CLEAR)
                begin
                    cmd.clear_start = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_FOUND;
                    state_next = S_DONE;
                end
                else if (sts.live_zero && sts.op != OP_INSERT)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_ABSENT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!sts.hash_busy)
                begin
                    cmd.probe_start = 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next = S_PROBE_KEY;
            end
            S_PROBE_KEY:
            begin
                state_next = S_PROBE_EV;
            end
            S_PROBE_EV:
            begin
                if (sts.slot_empty)
                begin
                    cmd.set_result = 1'b1;
                    if (sts.op == OP_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd.result_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                            cmd.result_status = ST_INSERTED;
                            cmd.result_index = 1'b1;
                            cmd.result_value = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.result_status = ST_ABSENT;
                    end
                    state_next = S_DONE;
                end
                else if (sts.key_match)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_FOUND;
                    cmd.result_index = 1'b1;
                    if (sts.op == OP_DELETE)
                    begin
                        cmd.do_delete = 1'b1;
                        cmd.shift_start = 1'b1;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.do_update = (sts.op == OP_INSERT);
                        cmd.result_value = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (sts.walk_last)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = (sts.op == OP_INSERT) ? ST_FULL : ST_ABSENT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next = S_SHIFT_CHK;
            end
            S_SHIFT_CHK:
            begin
                if (sts.shift_stop)
                begin
                    cmd.shift_end = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_LOAD;
                end
            end
            S_SHIFT_LOAD:
            begin
                cmd.hash_from_entry = 1'b1;
                cmd.hash_start = 1'b1;
                state_next = S_SHIFT_HASH;
            end
            S_SHIFT_HASH:
            begin
                if (!sts.hash_busy)
                begin
                    cmd.shift_move = sts.move_ok;
                    cmd.shift_adv = 1'b1;
                    state_next = S_SHIFT_RD;
                end
            end
            S_DONE:
            begin
                cmd.out_valid_set = 1'b1;
                if (sts.out_taken)
                begin
                    state_next = (sts.op == OP_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/olpht_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpht_dp
// Slot table, entry store, hash unit and walk counters.
// ----------------------------------------------------------------------------
module olpht_dp #(
    parameter int SLOT_COUNT  = olpht_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_DEPTH = olpht_pkg::ENTRY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            operation,
    input  logic [63:0]           key,
    input  logic [63:0]           new_value,
    output logic [1:0]            status,
    output logic [5:0]            entry_idx,
    output logic [63:0]           stored_value,
    output logic [6:0]            live_count,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  olpht_pkg::olpht_cmd_t cmd,
    output olpht_pkg::olpht_sts_t sts
);
    import olpht_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $clog2(ENTRY_DEPTH);
    localparam int CW = $clog2(ENTRY_DEPTH + 1);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int LIMIT = (SLOT_COUNT * 3) / 4;

    // slot word: valid bit and entry index, memory cleared by a sweep
    logic [EW:0]  slot_mem [SLOT_COUNT];
    logic [63:0]  key_mem  [ENTRY_DEPTH];
    logic [63:0]  val_mem  [ENTRY_DEPTH];
    logic [ENTRY_DEPTH-1:0] live_reg;

    logic [1:0]   op_reg;
    logic [63:0]  key_reg;
    logic [63:0]  nval_reg;
    logic [63:0]  h_reg;
    logic [63:0]  p_reg;
    olpht_hstep_t hstep_reg;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [31:0]  p_hi_sum;
    logic [63:0]  h_mid;
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] hole_reg;
    logic [NW-1:0] n_reg;
    logic [EW:0]  slot_rd_reg;
    logic [63:0]  ekey_rd_reg;
    logic [63:0]  eval_rd_reg;
    logic [CW-1:0] live_total_reg;
    logic [CW-1:0] cursor_reg;
    logic [SW-1:0] clr_reg;
    logic [1:0]   status_reg;
    logic [5:0]   index_reg;
    logic [63:0]  value_reg;
    logic         out_valid_reg;
    logic [SW-1:0] wr_addr;
    logic [EW:0]  wr_data;
    logic         wr_en;
    logic [EW-1:0] ent;
    logic [63:0]  h_fin;
    logic [SW-1:0] home;
    logic [SW-1:0] dh;
    logic [SW-1:0] ds;

    assign ent   = slot_rd_reg[EW-1:0];
    assign h_fin = h_reg ^ (h_reg >> 31);
    assign home  = h_fin[SW-1:0];
    assign dh    = hole_reg - home;
    assign ds    = cur_reg - home;

    always_comb
    begin
        mul_a = h_reg[31:0];
        mul_b = MIX_C1[31:0];
        case (hstep_reg)
            HS_C1_HL:
            begin
                mul_a = h_reg[63:32];
            end
            HS_C1_LH:
            begin
                mul_b = MIX_C1[63:32];
            end
            HS_C2_LL:
            begin
                mul_b = MIX_C2[31:0];
            end
            HS_C2_HL:
            begin
                mul_a = h_reg[63:32];
                mul_b = MIX_C2[31:0];
            end
            HS_C2_LH:
            begin
                mul_b = MIX_C2[63:32];
            end
            default:
            begin
                mul_a = h_reg[31:0];
            end
        endcase
    end

    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign p_hi_sum = p_reg[63:32] + mul_p[31:0];
    assign h_mid    = {p_hi_sum, p_reg[31:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= '0;
            p_reg     <= '0;
            hstep_reg <= HS_IDLE;
        end
        else if (cmd.hash_start)
        begin
            h_reg     <= mix_pre(cmd.hash_from_entry ? ekey_rd_reg : key_reg);
            hstep_reg <= HS_C1_LL;
        end
        else
        begin
            case (hstep_reg)
                HS_C1_LL:
                begin
                    p_reg     <= mul_p;
                    hstep_reg <= HS_C1_HL;
                end
                HS_C1_HL:
                begin
                    p_reg[63:32] <= p_hi_sum;
                    hstep_reg    <= HS_C1_LH;
                end
                HS_C1_LH:
                begin
                    h_reg     <= h_mid ^ (h_mid >> 27);
                    hstep_reg <= HS_C2_LL;
                end
                HS_C2_LL:
                begin
                    p_reg     <= mul_p;
                    hstep_reg <= HS_C2_HL;
                end
                HS_C2_HL:
                begin
                    p_reg[63:32] <= p_hi_sum;
                    hstep_reg    <= HS_C2_LH;
                end
                HS_C2_LH:
                begin
                    h_reg     <= h_mid;
                    hstep_reg <= HS_IDLE;
                end
                default:
                begin
                    hstep_reg <= HS_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = cur_reg;
        wr_data = '0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg;
        end
        else if (cmd.do_insert)
        begin
            wr_en = 1'b1;
            wr_data = {1'b1, cursor_reg[EW-1:0]};
        end
        else if (cmd.shift_move)
        begin
            wr_en = 1'b1;
            wr_addr = hole_reg;
            wr_data = slot_rd_reg;
        end
        else if (cmd.shift_end)
        begin
            wr_en = 1'b1;
            wr_addr = hole_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.probe_rd || cmd.shift_rd)
        begin
            slot_rd_reg <= slot_mem[cur_reg];
        end
        if (cmd.do_insert)
        begin
            key_mem[cursor_reg[EW-1:0]] <= key_reg;
        end
        if (cmd.do_insert || cmd.do_update)
        begin
            val_mem[cmd.do_insert ? cursor_reg[EW-1:0] : ent] <= nval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ekey_rd_reg <= key_mem[ent];
        eval_rd_reg <= val_mem[ent];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            nval_reg <= new_value;
        end
        if (cmd.probe_start)
        begin
            cur_reg <= home;
            n_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            cur_reg <= cur_reg + 1'b1;
            n_reg <= n_reg + 1'b1;
        end
        else if (cmd.shift_start)
        begin
            hole_reg <= cur_reg;
            cur_reg <= cur_reg + 1'b1;
            n_reg <= '0;
        end
        else if (cmd.shift_adv)
        begin
            if (cmd.shift_move)
            begin
                hole_reg <= cur_reg;
            end
            cur_reg <= cur_reg + 1'b1;
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.set_result)
        begin
            status_reg <= cmd.result_status;
            index_reg  <= '0;
            value_reg  <= '0;
            if (cmd.result_index)
            begin
                index_reg <= 6'(cmd.do_insert ? cursor_reg : CW'(ent));
            end
            if (cmd.result_value)
            begin
                value_reg <= (cmd.do_insert || cmd.do_update) ? nval_reg : eval_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            live_total_reg <= '0;
            cursor_reg     <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                live_reg       <= '0;
                live_total_reg <= '0;
                cursor_reg     <= '0;
                clr_reg        <= '0;
            end
            else if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.do_insert)
            begin
                live_reg[cursor_reg[EW-1:0]] <= 1'b1;
                live_total_reg <= live_total_reg + 1'b1;
                cursor_reg     <= cursor_reg + 1'b1;
            end
            if (cmd.do_delete)
            begin
                live_reg[ent]  <= 1'b0;
                live_total_reg <= live_total_reg - 1'b1;
            end
            if (cmd.out_valid_set && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status       = status_reg;
    assign entry_idx    = index_reg;
    assign stored_value = value_reg;
    assign live_count   = 7'(live_total_reg);
    assign rsp_valid    = out_valid_reg;

    always_comb
    begin
        sts = '0;
        sts.op         = op_reg;
        sts.clear_last = (clr_reg == SW'(SLOT_COUNT - 1));
        sts.live_zero  = (live_total_reg == '0);
        sts.hash_busy  = (hstep_reg != HS_IDLE);
        sts.slot_empty = !slot_rd_reg[EW];
        sts.key_match  = slot_rd_reg[EW] && live_reg[ent] && (ekey_rd_reg == key_reg);
        sts.walk_last  = (n_reg == NW'(SLOT_COUNT - 1));
        sts.full       = (32'(live_total_reg) + 32'd1 > 32'(LIMIT))
                         || (cursor_reg >= CW'(ENTRY_DEPTH));
        sts.move_ok    = (dh < ds);
        sts.shift_stop = !slot_rd_reg[EW] || (n_reg == NW'(SLOT_COUNT));
        sts.out_taken  = out_valid_reg && rsp_ready;
    end
endmodule

// ----- rtl/ordered_linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_linear_probe_hash_table
// Ordered 64-bit key/value table, linear probing, backward-shift delete.
//
// channel  dir  payload
// req      in   operation, key, new_value
// rsp      out  status, index, stored_value, live_count
//
// One transaction at a time. After req is taken: decode, hash, then for each
// slot probed a read, key fetch and evaluate, then rsp.valid rises. A delete hit
// adds a backward-shift walk: read, check, load and rehash per occupied slot, and
// a check of the slot that ends it. Clear, and lookup or delete on an empty table,
// skip hash and probe. Reset and clear sweep every slot before req.ready; else it
// returns the cycle after the rsp transaction, and rsp.ready low holds it.
// ----------------------------------------------------------------------------
module ordered_linear_probe_hash_table #(
    parameter int SLOT_COUNT  = olpht_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_DEPTH = olpht_pkg::ENTRY_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    olpht_if.sink   req,
    olpht_if.source rsp
);
    import olpht_pkg::*;

    olpht_cmd_t  cmd;
    olpht_sts_t  sts;
    logic [1:0]  status;
    logic [5:0]  entry_idx;
    logic [63:0] stored_value;
    logic [6:0]  live_count;

    olpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    olpht_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (req.data[129:128]),
        .key          (req.data[127:64]),
        .new_value    (req.data[63:0]),
        .status       (status),
        .entry_idx    (entry_idx),
        .stored_value (stored_value),
        .live_count   (live_count),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    assign rsp.data = {status, entry_idx, stored_value, live_count};
endmodule
